// File: src/nffla_pkg.sv
// Shared types and constants for the next-fit free-list allocator.
package nffla_pkg;

    localparam int KIND_W  = 2;
    localparam int BYTES_W = 16;
    localparam int ADDR_W  = 12;
    localparam int UNITS_W = 18;

    localparam int UNIT_BYTES = 16;

    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESIZE = 2'd2;

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_AFIRST = 12'b0000_0000_0100,
        S_ACHK   = 12'b0000_0000_1000,
        S_ASPLIT = 12'b0000_0001_0000,
        S_ADONE  = 12'b0000_0010_0000,
        S_FSTART = 12'b0000_0100_0000,
        S_FBSZ   = 12'b0000_1000_0000,
        S_FWALK  = 12'b0001_0000_0000,
        S_FNX    = 12'b0010_0000_0000,
        S_FWP    = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } t_state;

endpackage

// File: src/next_fit_free_list_allocator_top.sv
// Next-fit free-list heap allocator: sequencer, link/size memories and output register.
//
//  channel | dir | handshake                 | payload
//  s       | in  | i_s_tvalid / o_s_tready   | tdata: byte_count, block_address; tuser: kind
//  m       | out | o_m_tvalid / i_m_tready   | tdata: result_address; tuser: ok
//
// Each list node visited costs one registered read of the link/size memories:
// allocate reads the rover node and checks nodes in turn, with an extra step
// when a block is split; free reads the block size, walks the list, has an
// extra step when it merges with the next block, then updates the previous
// node; resize does both. The result then waits in the output register, and
// the sequencer passes through idle before the next transfer. After reset a
// clearing pass writes every memory entry, with o_s_tready low. The result is
// held in an output register until taken; no new item is accepted until then.
module next_fit_free_list_allocator_top
    import nffla_pkg::*;
#(
    parameter int HEAP_UNITS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [15:0] byte_count, [27:16] block_address, rest zero
    input  logic [7:0]  i_s_tuser,  // [1:0] kind, rest zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // [11:0] result_address, rest zero
    output logic [7:0]  o_m_tuser   // [0] ok, rest zero
);

    localparam int AW = $clog2(HEAP_UNITS);
    localparam int HW = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int CW = ((AW > UNITS_W) ? AW : UNITS_W) + 2;

    logic [AW-1:0] link_mem [HEAP_UNITS];
    logic [AW-1:0] size_mem [HEAP_UNITS];

    t_state             r_state,  n_state;
    logic [KIND_W-1:0]  r_kind,   n_kind;
    logic [UNITS_W-1:0] r_units,  n_units;
    logic [HW-1:0]      r_hdr,    n_hdr;
    logic [AW-1:0]      r_prev,   n_prev;
    logic [AW-1:0]      r_cur,    n_cur;
    logic [AW-1:0]      r_rover,  n_rover;
    logic [AW-1:0]      r_p,      n_p;
    logic [AW-1:0]      r_bsz,    n_bsz;
    logic [AW-1:0]      r_szp,    n_szp;
    logic [AW-1:0]      r_hsz,    n_hsz;
    logic [AW-1:0]      r_hlk,    n_hlk;
    logic [ADDR_W-1:0]  r_res,    n_res;
    logic               r_ok,     n_ok;
    logic [AW-1:0]      r_clr,    n_clr;
    logic [AW-1:0]      r_rd_link, r_rd_size;

    logic [AW-1:0] rd_addr;
    logic          w_link_en, w_size_en;
    logic [AW-1:0] w_addr, w_link, w_size;

    logic [AW-1:0] hdr_a;
    logic [AW:0]   p_end, h_end, new_cur, cur_plus1;
    logic [CW-1:0] sz_w, units_w;

    assign hdr_a     = r_hdr[AW-1:0];
    assign p_end     = (AW+1)'(r_p) + (AW+1)'(r_rd_size);
    assign h_end     = (AW+1)'(hdr_a) + (AW+1)'(r_bsz);
    assign sz_w      = CW'(r_rd_size);
    assign units_w   = CW'(r_units);
    assign new_cur   = (AW+1)'(r_cur) + (AW+1)'(r_rd_size) - (AW+1)'(r_units);
    assign cur_plus1 = (AW+1)'(r_cur) + (AW+1)'(1);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {{(16-ADDR_W){1'b0}}, r_res};
    assign o_m_tuser  = {7'd0, r_ok};

    always_comb begin
        n_state = r_state;   n_kind = r_kind;   n_units = r_units;  n_hdr = r_hdr;
        n_prev  = r_prev;    n_cur  = r_cur;    n_rover = r_rover;  n_p   = r_p;
        n_bsz   = r_bsz;     n_szp  = r_szp;    n_hsz   = r_hsz;
        n_hlk   = r_hlk;     n_res  = r_res;    n_ok    = r_ok;     n_clr = r_clr;
        rd_addr   = '0;
        w_link_en = 1'b0;
        w_size_en = 1'b0;
        w_addr    = '0;
        w_link    = '0;
        w_size    = '0;
        case (r_state)
            S_CLEAR: begin
                w_link_en = 1'b1;
                w_size_en = 1'b1;
                w_addr    = r_clr;
                w_link    = (r_clr == AW'(0)) ? AW'(1) : '0;
                w_size    = (r_clr == AW'(1)) ? AW'(HEAP_UNITS - 1) : '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(HEAP_UNITS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_kind  = i_s_tuser[KIND_W-1:0];
                    n_units = UNITS_W'((32'(i_s_tdata[15:0]) + UNIT_BYTES - 1) / UNIT_BYTES + 1);
                    n_hdr   = (i_s_tdata[27:16] == '0) ? HW'(HEAP_UNITS - 1)
                                                       : HW'(i_s_tdata[27:16]) - HW'(1);
                    n_res   = '0;
                    n_ok    = 1'b0;
                    if (i_s_tuser[KIND_W-1:0] == KIND_ALLOC ||
                        i_s_tuser[KIND_W-1:0] == KIND_RESIZE) begin
                        rd_addr = r_rover;
                        n_prev  = r_rover;
                        n_state = S_AFIRST;
                    end else if (i_s_tuser[KIND_W-1:0] == KIND_FREE) begin
                        n_state = S_FSTART;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_AFIRST: begin
                n_cur   = r_rd_link;
                rd_addr = r_rd_link;
                n_state = S_ACHK;
            end
            S_ACHK: begin
                if (sz_w >= units_w) begin
                    if (sz_w == units_w) begin
                        w_link_en = 1'b1;
                        w_addr    = r_prev;
                        w_link    = r_rd_link;
                        n_rover   = r_prev;
                        n_state   = S_ADONE;
                    end else begin
                        w_size_en = 1'b1;
                        w_addr    = r_cur;
                        w_size    = r_rd_size - AW'(r_units);
                        if (new_cur >= (AW+1)'(HEAP_UNITS)) begin
                            n_state = S_OUT;
                        end else begin
                            n_cur   = new_cur[AW-1:0];
                            n_state = S_ASPLIT;
                        end
                    end
                end else if (r_cur == r_rover) begin
                    n_state = S_OUT;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = r_rd_link;
                    rd_addr = r_rd_link;
                end
            end
            S_ASPLIT: begin
                w_size_en = 1'b1;
                w_addr    = r_cur;
                w_size    = AW'(r_units);
                n_rover   = r_prev;
                n_state   = S_ADONE;
            end
            S_ADONE: begin
                n_res   = (cur_plus1 == (AW+1)'(HEAP_UNITS)) ? '0 : ADDR_W'(cur_plus1);
                n_ok    = 1'b1;
                n_state = (r_kind == KIND_RESIZE) ? S_FSTART : S_OUT;
            end
            S_FSTART: begin
                if (r_hdr == '0 || (HW+1)'(r_hdr) >= (HW+1)'(HEAP_UNITS)) begin
                    n_state = S_OUT;
                end else begin
                    rd_addr = hdr_a;
                    n_state = S_FBSZ;
                end
            end
            S_FBSZ: begin
                n_bsz = r_rd_size;
                if (r_rd_size == '0 ||
                    (AW+1)'(r_rd_size) > (AW+1)'(HEAP_UNITS) - (AW+1)'(hdr_a)) begin
                    n_state = S_OUT;
                end else begin
                    n_p     = r_rover;
                    rd_addr = r_rover;
                    n_state = S_FWALK;
                end
            end
            S_FWALK: begin
                n_szp = r_rd_size;
                if (hdr_a == r_p || hdr_a == r_rd_link) begin
                    n_state = S_OUT;
                end else if ((hdr_a > r_p && hdr_a < r_rd_link) ||
                             (r_p >= r_rd_link && (hdr_a > r_p || hdr_a < r_rd_link))) begin
                    if ((hdr_a > r_p && (AW+1)'(hdr_a) < p_end) ||
                        (r_rd_link > hdr_a && h_end > (AW+1)'(r_rd_link))) begin
                        n_state = S_OUT;
                    end else if (h_end == (AW+1)'(r_rd_link)) begin
                        rd_addr = r_rd_link;
                        n_state = S_FNX;
                    end else begin
                        w_link_en = 1'b1;
                        w_addr    = hdr_a;
                        w_link    = r_rd_link;
                        n_hsz     = r_bsz;
                        n_hlk     = r_rd_link;
                        n_state   = S_FWP;
                    end
                end else begin
                    n_p     = r_rd_link;
                    rd_addr = r_rd_link;
                end
            end
            S_FNX: begin
                w_link_en = 1'b1;
                w_size_en = 1'b1;
                w_addr    = hdr_a;
                w_size    = r_bsz + r_rd_size;
                w_link    = r_rd_link;
                n_hsz     = r_bsz + r_rd_size;
                n_hlk     = r_rd_link;
                n_state   = S_FWP;
            end
            S_FWP: begin
                w_link_en = 1'b1;
                w_addr    = r_p;
                if ((AW+1)'(r_p) + (AW+1)'(r_szp) == (AW+1)'(hdr_a)) begin
                    w_size_en = 1'b1;
                    w_size    = r_szp + r_hsz;
                    w_link    = r_hlk;
                end else begin
                    w_link    = hdr_a;
                end
                n_rover = r_p;
                if (r_kind == KIND_FREE) begin
                    n_ok = 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_link_en) begin
            link_mem[w_addr] <= w_link;
        end
        if (w_size_en) begin
            size_mem[w_addr] <= w_size;
        end
        r_rd_link <= link_mem[rd_addr];
        r_rd_size <= size_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_rover <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_rover <= n_rover;
            r_clr   <= n_clr;
        end
        r_kind <= n_kind;  r_units <= n_units;  r_hdr <= n_hdr;  r_prev <= n_prev;
        r_cur  <= n_cur;   r_p     <= n_p;      r_bsz  <= n_bsz;
        r_szp  <= n_szp;   r_hsz   <= n_hsz;    r_hlk <= n_hlk;  r_res  <= n_res;
        r_ok   <= n_ok;
    end

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("accepting input while a result is pending");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("failed request reports a nonzero address");

    a_free_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_kind == KIND_FREE) |-> (o_m_tdata == '0))
        else $error("free reports an address");

    a_rover_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW+1)'(r_rover) < (AW+1)'(HEAP_UNITS))
        else $error("rover outside the pool");

endmodule
